[sv/lse_pkg.sv]
// ----------------------------------------------------------------------------
// lse_pkg: shared types and constants for the Legendre symbol block
// Widths of the modulus, value and symbol words and the word carried
// from the front to the back part.
// ----------------------------------------------------------------------------
package lse_pkg;
   localparam int ModWidth = 32;
   localparam int QW       = ModWidth - 1;   // kept modulus bits
   localparam int VW       = 32;
   localparam int SW       = 2;

   localparam logic [SW-1:0] SYM_ZERO = 2'd0;
   localparam logic [SW-1:0] SYM_POS  = 2'd1;
   localparam logic [SW-1:0] SYM_NEG  = 2'd3;

   typedef struct packed {
      logic          neg;   // value was negative
      logic [VW-1:0] mag;   // magnitude of the value
   } job_type;
endpackage

[sv/lse_front.sv]
// ----------------------------------------------------------------------------
// lse_front: input stage and word queue
// Takes value words, splits sign and magnitude and queues them for the back.
// ----------------------------------------------------------------------------
module lse_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [lse_pkg::VW-1:0] req_value,
   output logic                      job_valid,
   input  logic                      job_ready,
   output lse_pkg::job_type          job_data
);
   import lse_pkg::*;
   localparam int Depth = 4;
   localparam int AW    = 2;

   job_type       mem_ff [Depth];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push, pop;
   job_type       job_w;

   assign req_ready = (cnt_ff != AW'(0) + (AW+1)'(Depth));
   assign job_valid = (cnt_ff != '0);
   assign push = req_valid && req_ready;
   assign pop  = job_valid && job_ready;
   assign job_data = mem_ff[rd_ff];

   always_comb begin
      job_w.neg = req_value[VW-1];
      job_w.mag = req_value[VW-1] ? (~req_value + VW'(1)) : req_value;
      wr_in  = push ? wr_ff + AW'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + AW'(1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= job_w;
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(Depth)) else $error("queue overfill");
   a_push_cnt: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + (AW+1)'(1)) else $error("lost push");
   a_pop_cnt: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> cnt_ff == $past(cnt_ff) - (AW+1)'(1)) else $error("lost pop");
endmodule

[sv/lse_back.sv]
// ----------------------------------------------------------------------------
// lse_back: reduction and modular power engine
// Reduces the magnitude bit-serially, then runs square-and-multiply with a
// shift-add modular multiplier, one bit per cycle.
// ----------------------------------------------------------------------------
module lse_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [lse_pkg::QW-1:0] modulus,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  lse_pkg::job_type       job_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [lse_pkg::SW-1:0] rsp_symbol
);
   import lse_pkg::*;
   localparam logic [2:0] ST_IDLE = 3'd0, ST_RED = 3'd1, ST_FIX = 3'd2,
                          ST_STEP = 3'd3, ST_MUL = 3'd4, ST_DONE = 3'd5;
   localparam int CW = $clog2(VW + 1);

   logic [2:0]    st_ff, st_in;
   logic [QW-1:0] q_ff, q_in, r_ff, r_in, acc_ff, acc_in, b_ff, b_in;
   logic [QW-1:0] e_ff, e_in, x_ff, x_in, y_ff, y_in, p_ff, p_in;
   logic [VW-1:0] mag_ff, mag_in;
   logic          neg_ff, neg_in, sq_ff, sq_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ov_ff, ov_in;
   logic [SW-1:0] sym_ff, sym_in;
   logic [SW-1:0] out_ff, out_in;
   logic [QW:0]   t2, tp;
   logic [QW:0]   ds;
   logic [QW-1:0] dbl, sum;

   assign job_ready  = (st_ff == ST_IDLE);
   assign rsp_valid  = ov_ff;
   assign rsp_symbol = out_ff;

   always_comb begin
      st_in = st_ff; q_in = q_ff; r_in = r_ff; acc_in = acc_ff; b_in = b_ff;
      e_in = e_ff; x_in = x_ff; y_in = y_ff; p_in = p_ff; mag_in = mag_ff;
      neg_in = neg_ff; sq_in = sq_ff; cnt_in = cnt_ff; ov_in = ov_ff;
      sym_in = sym_ff; out_in = out_ff;
      // reduction step: r = 2r + bit mod q
      t2  = {r_ff, mag_ff[VW-1]};
      ds  = t2 - {1'b0, q_ff};
      // modmul step: p = 2p (+x) mod q, x MSB first over y
      dbl = ({p_ff, 1'b0} >= {1'b0, q_ff}) ? QW'({p_ff, 1'b0} - {1'b0, q_ff})
                                           : p_ff << 1;
      tp  = {1'b0, dbl} + (y_ff[QW-1] ? {1'b0, x_ff} : '0);
      sum = (tp >= {1'b0, q_ff}) ? QW'(tp - {1'b0, q_ff}) : tp[QW-1:0];
      if (rsp_valid && rsp_ready) ov_in = 1'b0;
      case (st_ff)
         ST_IDLE: if (job_valid) begin
            q_in = modulus; mag_in = job_data.mag; neg_in = job_data.neg;
            r_in = '0; cnt_in = CW'(VW);
            st_in = (modulus == '0) ? ST_DONE : ST_RED;
            sym_in = SYM_ZERO;
         end
         ST_RED: begin
            r_in   = (t2 >= {1'b0, q_ff}) ? ds[QW-1:0] : t2[QW-1:0];
            mag_in = mag_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) st_in = ST_FIX;
         end
         ST_FIX: begin
            if (r_ff == '0) begin
               sym_in = SYM_ZERO; st_in = ST_DONE;
            end else begin
               b_in = neg_ff ? q_ff - r_ff : r_ff;
               acc_in = (q_ff == QW'(1)) ? '0 : QW'(1);
               e_in = (q_ff - QW'(1)) >> 1;
               st_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (e_ff == '0) begin
               sym_in = (acc_ff == QW'(1)) ? SYM_POS : SYM_NEG;
               st_in = ST_DONE;
            end else begin
               sq_in = !e_ff[0];   // multiply first if bit set
               x_in = e_ff[0] ? acc_ff : b_ff;
               y_in = b_ff; p_in = '0; cnt_in = CW'(QW);
               st_in = ST_MUL;
            end
         end
         ST_MUL: begin
            p_in = sum; y_in = y_ff << 1; cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               if (!sq_ff) begin
                  acc_in = sum; sq_in = 1'b1; x_in = b_ff; y_in = b_ff;
                  p_in = '0; cnt_in = CW'(QW);
               end else begin
                  b_in = sum; e_in = e_ff >> 1; st_in = ST_STEP;
               end
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1; out_in = sym_ff; st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; acc_ff <= acc_in; b_ff <= b_in; e_ff <= e_in;
      x_ff <= x_in; y_ff <= y_in; p_ff <= p_in; mag_ff <= mag_in;
      neg_ff <= neg_in; sq_ff <= sq_in; cnt_ff <= cnt_in; sym_ff <= sym_in;
      out_ff <= out_in;
      if (reset) begin
         st_ff <= ST_IDLE; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol))
      else $error("result dropped");
   a_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_symbol != 2'd2) else $error("bad symbol code");
   a_take: assert property (@(posedge clock) disable iff (reset)
      job_valid && job_ready |=> st_ff != ST_IDLE) else $error("job lost");
endmodule

[sv/legendre_symbol_euler.sv]
// ----------------------------------------------------------------------------
// legendre_symbol_euler: Legendre symbol by Euler's criterion
// Front queue plus a serial reduce and modular power engine.
// ----------------------------------------------------------------------------
// The engine reduces each word bit-serially, then for each bit of (q-1)/2
// (up to 30 bits) passes the step state once and runs one or two shift-add
// modular multiplies. A zero residue skips the modular power, and a zero
// modulus skips the reduction as well. The single serial multiplier sets
// the rate. A four-word queue takes new words while the engine works, and
// an output register lets the engine start the next word while a result
// waits.
module legendre_symbol_euler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [lse_pkg::QW-1:0]        csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [lse_pkg::VW-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [lse_pkg::SW-1:0] rsp_symbol
);
   import lse_pkg::*;
   logic [QW-1:0] mod_ff;
   logic          job_valid, job_ready;
   job_type       job_data;

   always_ff @(posedge clock) begin
      if (reset) mod_ff <= QW'(3);
      else if (csr_we) mod_ff <= csr_wdata;
   end

   lse_front u_front (.clock, .reset, .req_valid, .req_ready, .req_value,
      .job_valid, .job_ready, .job_data);
   lse_back u_back (.clock, .reset, .modulus(mod_ff), .job_valid, .job_ready,
      .job_data, .rsp_valid, .rsp_ready, .rsp_symbol);
endmodule

[test/lse_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lse_checker: scoreboard for the Legendre symbol block
// Watches the request and response channels, predicts each symbol from the
// accepted value and the current modulus, and compares in order.
// ----------------------------------------------------------------------------
module lse_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [lse_pkg::QW-1:0]        csr_wdata,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [lse_pkg::VW-1:0] req_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [lse_pkg::SW-1:0] rsp_symbol,
   output int                            fail_count,
   output int                            pending
);
   import lse_pkg::*;

   logic [QW-1:0]   modulus_q;
   logic [SW-1:0]   symbol_queue[$];

   function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] q);
      return (a * b) % q;
   endfunction

   function automatic logic [SW-1:0] legendre(logic [VW-1:0] v, logic [QW-1:0] qm);
      logic [63:0] q;
      logic [63:0] mag;
      logic [63:0] r;
      logic [63:0] e;
      logic [63:0] acc;
      logic [63:0] b;
      q = 64'(qm);
      if (q == 0) return SYM_ZERO;
      if (!v[VW-1]) begin
         r = 64'(v) % q;
      end else begin
         mag = 64'h1_0000_0000 - 64'(v);
         r = mag % q;
         if (r != 0) r = q - r;
      end
      if (r == 0) return SYM_ZERO;
      e = (q - 1) >> 1;
      acc = 1 % q;
      b = r;
      while (e != 0) begin
         if (e[0]) acc = mulmod(acc, b, q);
         b = mulmod(b, b, q);
         e = e >> 1;
      end
      return (acc == 1) ? SYM_POS : SYM_NEG;
   endfunction

   assign pending = symbol_queue.size();

   always @(posedge clock) begin
      logic [SW-1:0] want;
      if (reset) begin
         modulus_q <= QW'(3);
         symbol_queue.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            symbol_queue.push_back(legendre(req_value, modulus_q));
         if (rsp_valid && rsp_ready) begin
            if (symbol_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected word: symbol %0d", rsp_symbol);
            end else begin
               want = symbol_queue.pop_front();
               if (rsp_symbol !== want) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("symbol mismatch: q=%0d expected %0d got %0d",
                              modulus_q, $signed(want), rsp_symbol);
               end
            end
         end
         if (csr_we) modulus_q <= csr_wdata;
      end
   end

   final begin
      if (symbol_queue.size() != 0)
         $display("%0d expected words never arrived", symbol_queue.size());
   end
endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus for the Legendre symbol block
// Walks several moduli (extremes, small primes, even and composite values),
// sends directed and random values with random gaps and stalls, and reports.
// ----------------------------------------------------------------------------
module testbench;
   import lse_pkg::*;

   localparam int CycleLimit = 20000000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  csr_we = 0;
   logic [QW-1:0]         csr_wdata = '0;
   logic                  req_valid = 0;
   logic                  req_ready;
   logic signed [VW-1:0]  req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 0;
   logic signed [SW-1:0]  rsp_symbol;
   int                    fail_count;
   int                    pending;
   int                    cycles = 0;
   bit                    calm = 0;

   always #1 clock = ~clock;

   legendre_symbol_euler uut (.*);

   lse_checker u_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("[legendre_symbol_euler] ERROR");
         $finish;
      end
   end

   // response stalls, none during the calm stretch
   always @(posedge clock)
      rsp_ready <= calm || ($urandom_range(99) >= 6);

   // leave valid high after the accept; the next word replaces or drops it, or drain() drops it
   task automatic send_word(logic [VW-1:0] v);
      while (!calm && $urandom_range(99) < 6) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
   endtask

   task automatic set_modulus(logic [QW-1:0] q);
      drain();
      csr_we <= 1;
      csr_wdata <= q;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   function automatic logic [VW-1:0] rand_value(logic [QW-1:0] q);
      case ($urandom_range(5))
         0: return $urandom_range(0, 8);
         1: return -$urandom_range(0, 8);
         2: return 32'(q) * $urandom_range(0, 3);
         3: return -(32'(q) * $urandom_range(0, 3)) + $urandom_range(0, 2);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [QW-1:0] moduli[12];
      logic [VW-1:0] edges[10];
      moduli = '{3, 0, 1, 2, 31'h7FFF_FFFF, 7, 31'h7FFF_FFED, 4, 15, 101, 65537,
                 31'h7FFF_FFFE};
      edges = '{0, 1, -1, 2, -2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                3, -3};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (moduli[m]) begin
         set_modulus(moduli[m]);
         if (m < 3) foreach (edges[i]) send_word(edges[i]);
         calm = (m == 5);
         repeat (m < 3 ? 60 : 160) send_word(rand_value(moduli[m]));
         calm = 0;
      end
      drain();
      if (fail_count == 0) begin
         $display("[legendre_symbol_euler] OK");
      end else begin
         $display("[legendre_symbol_euler] ERROR");
      end
      $finish;
   end
endmodule
